/* src/ole_pkg.sv */
// Package for the ordered list engine: command, status and cell-op types.
`timescale 1ns / 1ps
package ole_pkg;
   localparam int unsigned DefCapacity = 16;
   localparam int unsigned PosWidth    = 5;
   localparam int unsigned ValWidth    = 32;

   typedef enum logic [3:0] {
      KIND_PUSH_FRONT = 4'd0,
      KIND_PUSH_BACK  = 4'd1,
      KIND_POP_FRONT  = 4'd2,
      KIND_POP_BACK   = 4'd3,
      KIND_READ       = 4'd4,
      KIND_INSERT     = 4'd5,
      KIND_ERASE      = 4'd6,
      KIND_NTH_END    = 4'd7,
      KIND_REVERSE    = 4'd8,
      KIND_REMOVE     = 4'd9
   } kind_type;

   typedef enum logic [2:0] {
      ST_OK       = 3'd0,
      ST_EMPTY    = 3'd1,
      ST_RANGE    = 3'd2,
      ST_FULL     = 3'd3,
      ST_NOTFOUND = 3'd4
   } status_type;

   // Per-cycle instruction broadcast to every cell.
   typedef enum logic [2:0] {
      OP_HOLD    = 3'd0,
      OP_OPEN    = 3'd1,   // pivot cell takes value, cells above take left
      OP_CLOSE   = 3'd2,   // cells at or above pivot take right neighbour
      OP_MIRROR  = 3'd3,   // cells below count take mirrored entry
      OP_WRITE   = 3'd4    // cell at pivot takes the value
   } cell_op_type;

   typedef struct packed {
      cell_op_type          op;
      logic [PosWidth+3:0]  pivot;
      logic [ValWidth-1:0]  value;
   } cell_ctl_type;
endpackage

/* src/ole_cell.sv */
// One storage cell of the list: holds a single entry and shifts with its neighbours.
`timescale 1ns / 1ps
module ole_cell
   import ole_pkg::*;
#(
   parameter int unsigned INDEX = 0
) (
   input  logic                clock,
   input  cell_ctl_type        ctl,
   input  logic                write_here,
   input  logic [ValWidth-1:0] left_value,
   input  logic [ValWidth-1:0] right_value,
   input  logic [ValWidth-1:0] mirror_value,
   input  logic                mirror_en,
   output logic [ValWidth-1:0] value
);
   logic [ValWidth-1:0] value_ff, value_in;
   logic                at_or_above;

   assign at_or_above = ((PosWidth+4)'(INDEX) >= ctl.pivot);

   always_comb begin
      value_in = value_ff;
      case (ctl.op)
         OP_OPEN: begin
            if (write_here) value_in = ctl.value;
            else if (at_or_above) value_in = left_value;
         end
         OP_CLOSE:  if (at_or_above) value_in = right_value;
         OP_MIRROR: if (mirror_en) value_in = mirror_value;
         OP_WRITE:  if (write_here) value_in = ctl.value;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   assign value = value_ff;
endmodule

/* src/ordered_list_engine.sv */
// Top level of the ordered list engine: command decode, count and the row of cells.
//  channel | direction | contents
//  req_    | in        | tuser=kind, tdata={item_value,position}
//  rsp_    | out       | tuser=status, tdata=result fields
// Cells update as a command is accepted; its registered result is valid the cycle after.
// A new command is taken in any cycle in which the waiting result is taken or none waits,
// so one command per cycle is sustained while the receiver keeps up.
// Synchronous reset clears the count and output valid; entries stay undefined.
// A stalled result stops the request side only when the output register is full.
`timescale 1ns / 1ps
module ordered_list_engine
   import ole_pkg::*;
#(
   parameter int unsigned CAPACITY = DefCapacity
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [3:0]   req_tuser,   // kind
   input  logic [39:0]  req_tdata,   // position[4:0], item_value[36:5], zeros
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [2:0]   rsp_tuser,   // status
   output logic [103:0] rsp_tdata    // read_value, entry_count, is_empty, first, last
);
   localparam int unsigned CW = $clog2(CAPACITY + 1);
   localparam int unsigned PW = PosWidth + 4;
   localparam int unsigned IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

   logic [ValWidth-1:0] ent [CAPACITY];
   logic [CW-1:0]       count_ff, count_in;
   logic                vld_ff;
   logic [2:0]          st_ff, st_in;
   logic [ValWidth-1:0] rd_ff, rd_in;
   logic                acc;
   cell_ctl_type        ctl;
   cell_ctl_type        ctl_g;
   logic [PW-1:0]       cnt_w, pos_w, match_idx;
   logic                match_found;
   logic [ValWidth-1:0] first_v, last_v;
   kind_type            kind;
   logic [PosWidth-1:0] pos;
   logic [ValWidth-1:0] val;

   assign kind = kind_type'(req_tuser);
   assign pos  = req_tdata[4:0];
   assign val  = req_tdata[36:5];
   assign cnt_w = PW'(count_ff);
   assign pos_w = PW'(pos);
   assign req_tready = !reset && (!vld_ff || rsp_tready);
   assign acc = req_tvalid && req_tready;

   always_comb begin
      match_found = 1'b0;
      match_idx   = '0;
      for (int i = CAPACITY - 1; i >= 0; i--) begin
         if (PW'(i) < cnt_w && ent[i] == val) begin
            match_found = 1'b1;
            match_idx   = PW'(i);
         end
      end
   end

   always_comb begin
      ctl.op = OP_HOLD; ctl.pivot = '0; ctl.value = val;
      count_in = count_ff; st_in = ST_OK; rd_in = '0;
      unique case (kind) inside
         KIND_PUSH_FRONT, KIND_PUSH_BACK: begin
            if (cnt_w >= PW'(CAPACITY)) st_in = ST_FULL;
            else begin
               ctl.op = OP_OPEN;
               ctl.pivot = (kind == KIND_PUSH_FRONT) ? '0 : cnt_w;
               count_in = count_ff + 1'b1;
            end
         end
         KIND_POP_FRONT, KIND_POP_BACK: begin
            if (count_ff == '0) st_in = ST_EMPTY;
            else begin
               ctl.op = OP_CLOSE;
               ctl.pivot = (kind == KIND_POP_FRONT) ? '0 : cnt_w - 1'b1;
               rd_in = (kind == KIND_POP_FRONT) ? first_v : last_v;
               count_in = count_ff - 1'b1;
            end
         end
         KIND_READ: begin
            if (pos_w >= cnt_w) st_in = ST_RANGE;
            else rd_in = ent[IW'(pos_w)];
         end
         KIND_INSERT: begin
            if (pos_w > cnt_w) st_in = ST_RANGE;
            else if (cnt_w >= PW'(CAPACITY)) st_in = ST_FULL;
            else begin
               ctl.op = OP_OPEN; ctl.pivot = pos_w; count_in = count_ff + 1'b1;
            end
         end
         KIND_ERASE: begin
            if (pos_w >= cnt_w) st_in = ST_RANGE;
            else begin
               ctl.op = OP_CLOSE; ctl.pivot = pos_w; count_in = count_ff - 1'b1;
            end
         end
         KIND_NTH_END: begin
            if (pos == '0 || pos_w > cnt_w) st_in = ST_RANGE;
            else rd_in = ent[IW'(cnt_w - pos_w)];
         end
         KIND_REVERSE: ctl.op = OP_MIRROR;
         KIND_REMOVE: begin
            if (!match_found) st_in = ST_NOTFOUND;
            else begin
               ctl.op = OP_CLOSE; ctl.pivot = match_idx; count_in = count_ff - 1'b1;
            end
         end
         default: ;
      endcase
   end

   // The cells see the command only in a cycle in which it is accepted.
   always_comb begin
      ctl_g = ctl;
      if (!acc) ctl_g.op = OP_HOLD;
   end

   for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
      localparam int unsigned L = (g == 0) ? 0 : g - 1;
      localparam int unsigned R = (g + 1 < CAPACITY) ? g + 1 : g;
      logic [PW-1:0] mi;
      assign mi = cnt_w - 1'b1 - PW'(g);
      ole_cell #(.INDEX(g)) u_cell (
         .clock        (clock),
         .ctl          (ctl_g),
         .write_here   (acc && ctl_g.pivot == PW'(g)),
         .left_value   (ent[L]),
         .right_value  (ent[R]),
         .mirror_value (ent[IW'(mi)]),
         .mirror_en    (acc && PW'(g) < cnt_w),
         .value        (ent[g])
      );
   end

   logic [ValWidth-1:0] nf, nl;
   logic [CW-1:0]       oc_ff;
   logic [ValWidth-1:0] of_ff, ol_ff;
   assign first_v = ent[0];
   assign last_v  = ent[IW'(cnt_w - 1'b1)];

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0; vld_ff <= 1'b0;
      end else begin
         if (acc) begin
            count_ff <= count_in; vld_ff <= 1'b1;
         end else if (rsp_tready) vld_ff <= 1'b0;
      end
      if (acc) begin
         st_ff <= st_in; rd_ff <= rd_in;
      end
   end

   assign nf = (count_ff == '0) ? '0 : first_v;
   assign nl = (count_ff == '0) ? '0 : last_v;
   assign oc_ff = count_ff;
   assign of_ff = nf;
   assign ol_ff = nl;

   assign rsp_tvalid = vld_ff;
   assign rsp_tuser  = st_ff;
   assign rsp_tdata  = {2'b00, ol_ff, of_ff, (oc_ff == '0), 5'(oc_ff), rd_ff};
endmodule

/* sim/tb_ordered_list_engine.sv */
// Self-checking testbench for the ordered list engine, with a scoreboard class.
`timescale 1ns / 1ps
module tb_ordered_list_engine;
   import ole_pkg::*;

   localparam int Depth = 16;

   typedef struct packed {
      logic [31:0] read_value;
      status_type  status;
      logic [4:0]  entry_count;
      logic        is_empty;
      logic [31:0] first_value;
      logic [31:0] last_value;
   } list_result_type;

   class list_scoreboard;
      logic [31:0]     store[Depth];
      int              fill;
      list_result_type pending[$];
      int              mismatches;

      function new();
         fill = 0;
         mismatches = 0;
      endfunction

      function void shift_out(int at);
         for (int i = at; i + 1 < fill; i++) store[i] = store[i + 1];
         fill--;
      endfunction

      function void shift_in(int at, logic [31:0] v);
         for (int i = fill; i > at; i--) store[i] = store[i - 1];
         store[at] = v;
         fill++;
      endfunction

      // Applies one command to the shadow list and queues the result it gives.
      function void note_command(logic [3:0] kind, int pos, logic [31:0] v);
         list_result_type r;
         logic [31:0] t;
         r = '0;
         r.status = ST_OK;
         case (kind) inside
            KIND_PUSH_FRONT, KIND_PUSH_BACK: begin
               if (fill >= Depth) r.status = ST_FULL;
               else shift_in((kind == KIND_PUSH_FRONT) ? 0 : fill, v);
            end
            KIND_POP_FRONT, KIND_POP_BACK: begin
               if (fill == 0) r.status = ST_EMPTY;
               else begin
                  r.read_value = (kind == KIND_POP_FRONT) ? store[0] : store[fill - 1];
                  shift_out((kind == KIND_POP_FRONT) ? 0 : fill - 1);
               end
            end
            KIND_READ: begin
               if (pos >= fill) r.status = ST_RANGE;
               else r.read_value = store[pos];
            end
            KIND_INSERT: begin
               if (pos > fill) r.status = ST_RANGE;
               else if (fill >= Depth) r.status = ST_FULL;
               else shift_in(pos, v);
            end
            KIND_ERASE: begin
               if (pos >= fill) r.status = ST_RANGE;
               else shift_out(pos);
            end
            KIND_NTH_END: begin
               if (pos == 0 || pos > fill) r.status = ST_RANGE;
               else r.read_value = store[fill - pos];
            end
            KIND_REVERSE: begin
               for (int i = 0; i < fill / 2; i++) begin
                  t = store[i];
                  store[i] = store[fill - 1 - i];
                  store[fill - 1 - i] = t;
               end
            end
            KIND_REMOVE: begin
               r.status = ST_NOTFOUND;
               for (int i = 0; i < fill; i++) begin
                  if (store[i] == v) begin
                     shift_out(i);
                     r.status = ST_OK;
                     break;
                  end
               end
            end
            default: ;
         endcase
         r.entry_count = fill[4:0];
         r.is_empty = (fill == 0);
         r.first_value = (fill == 0) ? '0 : store[0];
         r.last_value = (fill == 0) ? '0 : store[fill - 1];
         pending.insert(pending.size(), r);
      endfunction

      function void check_result(list_result_type got);
         list_result_type want;
         if (pending.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result %h", got);
            return;
         end
         want = pending[0];
         pending.delete(0);
         if (got !== want) begin
            mismatches++;
            if (mismatches <= 10)
               $display("rd %h/%h st %0d/%0d cnt %0d/%0d emp %b/%b f %h/%h l %h/%h",
                  want.read_value, got.read_value, want.status, got.status,
                  want.entry_count, got.entry_count, want.is_empty, got.is_empty,
                  want.first_value, got.first_value, want.last_value, got.last_value);
         end
      endfunction
   endclass

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [3:0]   req_tuser = '0;
   logic [39:0]  req_tdata = '0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [2:0]   rsp_tuser;
   logic [103:0] rsp_tdata;

   list_scoreboard board = new();
   int           cycles = 0;
   int           hold_off = 0;
   bit           random_phase = 1'b0;
   bit           long_done = 1'b0;

   ordered_list_engine dut (.*);

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // tdata from the lowest bit: read_value, entry_count, is_empty, first, last.
   always @(posedge clock) begin
      list_result_type got;
      cycles <= cycles + 1;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.read_value  = rsp_tdata[31:0];
         got.status      = status_type'(rsp_tuser);
         got.entry_count = rsp_tdata[36:32];
         got.is_empty    = rsp_tdata[37];
         got.first_value = rsp_tdata[69:38];
         got.last_value  = rsp_tdata[101:70];
         board.check_result(got);
      end
      if (cycles > 200000) begin
         $display("FAIL");
         $finish;
      end
   end

   // Receiver: own stall pattern, plus long hold-offs once random traffic starts.
   always @(posedge clock) begin
      if (reset) rsp_tready <= 1'b0;
      else if (hold_off > 0) begin
         hold_off <= hold_off - 1;
         rsp_tready <= 1'b0;
      end else if (random_phase && !long_done) begin
         hold_off <= 60;
         long_done <= 1'b1;
      end else if (random_phase && $urandom_range(0, 400) == 0)
         hold_off <= 60;
      else if (cycles[9]) rsp_tready <= 1'b1;
      else rsp_tready <= ($urandom_range(0, 3) != 0);
   end

   task automatic send(logic [3:0] kind, logic [4:0] pos, logic [31:0] v);
      req_tvalid <= 1'b1;
      req_tuser <= kind;
      req_tdata <= {3'b000, v, pos};
      do @(posedge clock); while (!req_tready);
      board.note_command(kind, pos, v);
   endtask

   task automatic idle_gap();
      req_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clock);
   endtask

   function automatic logic [31:0] pick_value();
      case ($urandom_range(0, 4))
         0: return 32'h8000_0000;
         1: return 32'h7fff_ffff;
         2: return 32'hffff_ffff;
         3: return 32'($urandom_range(0, 7));
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [3:0] pick_kind();
      int p;
      p = $urandom_range(0, 99);
      if (p < 30) return p[0] ? KIND_PUSH_BACK : KIND_PUSH_FRONT;
      if (p < 40) return KIND_INSERT;
      if (p < 97) return 4'($urandom_range(2, 9));
      return 4'($urandom_range(10, 15));
   endfunction

   initial begin
      int burst;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      // Directed: empty-store errors, fill to full, overflow, range checks.
      send(KIND_POP_FRONT, 0, 0);
      send(KIND_POP_BACK, 0, 0);
      send(KIND_READ, 0, 0);
      send(KIND_ERASE, 0, 0);
      send(KIND_NTH_END, 1, 0);
      send(KIND_REVERSE, 0, 0);
      send(KIND_REMOVE, 0, 32'h5);
      send(KIND_INSERT, 1, 32'h1);
      send(KIND_PUSH_BACK, 0, 32'h8000_0000);
      send(KIND_REVERSE, 0, 0);
      send(KIND_PUSH_FRONT, 0, 32'h7fff_ffff);
      for (int i = 0; i < 14; i++) send(KIND_INSERT, 5'(i % 3), 32'(i));
      send(KIND_PUSH_FRONT, 0, 32'hffff_ffff);
      send(KIND_INSERT, 16, 32'h9);
      send(KIND_INSERT, 17, 32'h9);
      send(KIND_READ, 15, 0);
      send(KIND_READ, 16, 0);
      send(KIND_NTH_END, 16, 0);
      send(KIND_NTH_END, 0, 0);
      send(KIND_NTH_END, 31, 0);
      send(KIND_REVERSE, 0, 0);
      send(KIND_REMOVE, 0, 32'h7fff_ffff);
      send(KIND_ERASE, 14, 0);
      send(4'd15, 5'd31, 32'hffff_ffff);
      random_phase = 1'b1;
      for (int n = 0; n < 900; n += burst) begin
         burst = $urandom_range(1, 20);
         for (int k = 0; k < burst; k++)
            send(pick_kind(), 5'($urandom_range(0, 17) == 17 ? $urandom : $urandom_range(0, 16)),
                 pick_value());
         if ($urandom_range(0, 2) != 0) idle_gap();
      end
      req_tvalid <= 1'b0;
      while (board.pending.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (board.mismatches == 0) $display("PASS");
      else $display("FAIL");
      $finish;
   end
endmodule

/* sim.f */
src/ole_pkg.sv
src/ole_cell.sv
src/ordered_list_engine.sv
sim/tb_ordered_list_engine.sv
